@@ rtl/cdrc_pkg.sv @@
package cdrc_pkg;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ALARM_LEVEL = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE_STEP    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TREND_THRESHOLD  = 4'd3;

  localparam logic [9:0] TARGET_LEVEL_RST     = 10'd200;
  localparam logic [9:0] HIGH_ALARM_LEVEL_RST = 10'd400;
  localparam logic [6:0] MAX_RATE_STEP_RST    = 7'd10;
  localparam logic [9:0] TREND_THRESHOLD_RST  = 10'd50;
  localparam logic [9:0] HIST_OLDEST_RST      = 10'd200;

  localparam logic [1:0] MODE_ALARM    = 2'd0;
  localparam logic [1:0] MODE_REGULATE = 2'd1;
  localparam logic [1:0] MODE_DISABLED = 2'd2;

  localparam logic [6:0]  PCT_MAX       = 7'd100;
  localparam logic [11:0] RAW40_MAX     = 12'd4000;
  localparam logic [15:0] DAMP_OFFSET   = 16'd400;
  // floor(x / 5) = (x * 205) >> 10 holds for every x up to 500.
  localparam logic [17:0] DIV5_RECIP    = 18'd205;

  typedef logic [9:0] level_t;
  typedef logic [6:0] pct_t;

endpackage

@@ rtl/chlorine_dosing_rate_controller.sv @@
// Items move from the input register to the result register, which drives the outputs.
// Throughput: one item per cycle while out_ready is high and no write is pending; the
// pump rate and history update at each such move, ready for the next item.
// A register write waits until the input register is empty and holds off input meanwhile.
// Reset (rst_n low, synchronous) clears both valid flags, the last pump rate and the
// history (oldest entry 200, others 0), and loads the register defaults.
module chlorine_dosing_rate_controller
  import cdrc_pkg::*;
#(
  parameter int HISTORY_DEPTH = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [9:0]           in_flow_lpm,
  input  logic [9:0]           in_chlorine_level,
  input  logic                 in_plant_enabled,
  input  logic                 in_schedule_allows,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [6:0]           out_pump_percent,
  output logic [1:0]           out_mode_code,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  level_t target_r, alarm_r, thresh_r;
  pct_t   step_r;

  logic   s1_vld_r;
  level_t s1_flow_r, s1_cl_r;
  logic   s1_plant_r, s1_sched_r;

  logic       out_vld_r;
  pct_t       out_pct_r;
  logic [1:0] out_mode_r;

  pct_t   last_r;
  level_t hist_r [HISTORY_DEPTH];

  logic s1_adv;

  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  // A pending register write keeps new items out so every item sees settled settings.
  assign in_ready = (!s1_vld_r || s1_adv) && !cfg_valid;
  assign cfg_ready = !s1_vld_r;

  assign out_valid        = out_vld_r;
  assign out_pump_percent = out_pct_r;
  assign out_mode_code    = out_mode_r;

  // Datapath for the item in the input register.
  logic signed [10:0] trend, tdiff;
  logic               rising;
  logic [11:0]        flow3;
  logic signed [15:0] raw40;
  logic [11:0]        raw_c;
  logic [17:0]        prod;
  pct_t               raw_pct;
  logic signed [7:0]  diff, step_s, delta;
  logic signed [8:0]  sum;
  pct_t               rate, pct_nxt;
  logic [1:0]         mode_nxt;

  always_comb begin
    // After the shift the oldest entry is the one now at index 1.
    trend  = $signed({1'b0, s1_cl_r}) - $signed({1'b0, hist_r[1]});
    rising = trend > $signed({1'b0, thresh_r});
    flow3  = {1'b0, s1_flow_r, 1'b0} + {2'b00, s1_flow_r};
    tdiff  = $signed({1'b0, target_r}) - $signed({1'b0, s1_cl_r});
    raw40  = $signed({4'b0000, flow3}) + $signed({{2{tdiff[10]}}, tdiff, 3'b000})
           - (rising ? $signed(DAMP_OFFSET) : 16'sd0);
    if (raw40 < 16'sd0) begin
      raw_c = 12'd0;
    end else if (raw40 > $signed({4'b0000, RAW40_MAX})) begin
      raw_c = RAW40_MAX;
    end else begin
      raw_c = raw40[11:0];
    end
    // Divide by 40 as a shift by 3 and a reciprocal multiply for 5.
    prod    = 18'(raw_c[11:3]) * DIV5_RECIP;
    raw_pct = prod[16:10];
    diff    = $signed({1'b0, raw_pct}) - $signed({1'b0, last_r});
    step_s  = $signed({1'b0, step_r});
    if (diff > step_s) begin
      delta = step_s;
    end else if (diff < -step_s) begin
      delta = -step_s;
    end else begin
      delta = diff;
    end
    sum = $signed({2'b00, last_r}) + $signed({delta[7], delta});
    if (sum < 9'sd0) begin
      rate = 7'd0;
    end else if (sum > $signed({2'b00, PCT_MAX})) begin
      rate = PCT_MAX;
    end else begin
      rate = sum[6:0];
    end
    if (s1_cl_r >= alarm_r) begin
      pct_nxt  = 7'd0;
      mode_nxt = MODE_ALARM;
    end else if (s1_plant_r && s1_sched_r) begin
      pct_nxt  = rate;
      mode_nxt = MODE_REGULATE;
    end else begin
      pct_nxt  = 7'd0;
      mode_nxt = MODE_DISABLED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_LEVEL_RST;
      alarm_r  <= HIGH_ALARM_LEVEL_RST;
      step_r   <= MAX_RATE_STEP_RST;
      thresh_r <= TREND_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_LEVEL:     target_r <= cfg_data[9:0];
        REG_HIGH_ALARM_LEVEL: alarm_r  <= cfg_data[9:0];
        REG_MAX_RATE_STEP:    step_r   <= cfg_data[6:0];
        REG_TREND_THRESHOLD:  thresh_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_flow_r  <= in_flow_lpm;
      s1_cl_r    <= in_chlorine_level;
      s1_plant_r <= in_plant_enabled;
      s1_sched_r <= in_schedule_allows;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pct_r  <= pct_nxt;
      out_mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 7'd0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= (i == 0) ? HIST_OLDEST_RST : 10'd0;
      end
    end else if (s1_adv) begin
      last_r <= pct_nxt;
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
      hist_r[HISTORY_DEPTH-1] <= s1_cl_r;
    end
  end

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_pct_r <= PCT_MAX)
    else $error("pump rate above 100 percent");

  a_off_modes: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_mode_r == MODE_ALARM || out_mode_r == MODE_DISABLED)
      |-> out_pct_r == 7'd0)
    else $error("pump running in alarm or disabled mode");

  a_last_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> last_r == out_pct_r)
    else $error("last pump rate does not match the delivered result");

  a_hist_newest: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> hist_r[HISTORY_DEPTH-1] == $past(s1_cl_r))
    else $error("history did not take the newest reading");

endmodule
